@@ hdl/tlik_pkg.sv @@
// Shared types, constants and arithmetic helpers for the two-link inverse kinematics unit.
package tlik_pkg;

   // default parameter values
   localparam int FRAC_BITS_DEF     = 16;
   localparam int CORDIC_STAGES_DEF = 18;
   localparam int TABLE_LEN         = 30;

   // datapath widths
   localparam int CW    = 54;   // CORDIC vector width
   localparam int ANG_W = 34;   // Q30 angle accumulator width

   // configuration register indexes
   localparam int CSR_ADDR_W = 4;
   localparam logic [CSR_ADDR_W-1:0] CSR_UPPER_LEN    = 4'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_LOWER_LEN    = 4'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_UPPER_OFFSET = 4'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_LOWER_OFFSET = 4'd3;

   localparam logic [18:0] LINK_LEN_RESET = 19'd19661;

   // Q30 turn constants
   localparam logic [31:0] Q30_QUARTER = 32'd1686629713;
   localparam logic [31:0] Q30_HALF    = 32'd3373259426;
   localparam logic [32:0] Q30_FULL    = 33'd6746518852;

   // floor(2^52 / full turn), used for the coarse turn count
   localparam logic [20:0] TURN_RECIP = 21'd667544;

   // atan(2^-i) in Q30
   localparam logic [31:0] ATAN_Q30 [0:TABLE_LEN-1] = '{
      32'd843314857, 32'd497837829, 32'd263043837, 32'd133525159, 32'd67021687,
      32'd33543516, 32'd16775851, 32'd8388437, 32'd4194283, 32'd2097149,
      32'd1048576, 32'd524288, 32'd262144, 32'd131072, 32'd65536, 32'd32768,
      32'd16384, 32'd8192, 32'd4096, 32'd2048, 32'd1024, 32'd512, 32'd256,
      32'd128, 32'd64, 32'd32, 32'd16, 32'd8, 32'd4, 32'd2
   };

   // per-request side data carried down the pipe
   typedef struct packed {
      logic               neg;
      logic               sat;
      logic               far;
      logic signed [19:0] ty;
      logic signed [19:0] tz;
   } side_type;

   // one CORDIC lane
   typedef struct packed {
      logic signed [CW-1:0]    x;
      logic signed [CW-1:0]    y;
      logic signed [ANG_W-1:0] acc;
      logic                    zero;
   } cvec_type;

   // quarter-turn pre-rotation into the right half plane
   function automatic cvec_type pre_rotate(input logic signed [CW-1:0] y,
                                           input logic signed [CW-1:0] x);
      cvec_type r;
      r.zero = (x == '0) && (y == '0);
      r.x    = x;
      r.y    = y;
      r.acc  = '0;
      if (x < 0) begin
         if (y >= 0) begin
            r.x   = y;
            r.y   = -x;
            r.acc = $signed(ANG_W'(Q30_QUARTER));
         end else begin
            r.x   = -y;
            r.y   = x;
            r.acc = -$signed(ANG_W'(Q30_QUARTER));
         end
      end
      return r;
   endfunction

   // one vectoring micro-rotation, floor shifts
   function automatic cvec_type cordic_step(input cvec_type v, input int unsigned i);
      cvec_type                r;
      logic signed [CW-1:0]    dx;
      logic signed [CW-1:0]    dy;
      logic signed [ANG_W-1:0] t;
      dx = v.y >>> i;
      dy = v.x >>> i;
      t  = $signed(ANG_W'(ATAN_Q30[i[4:0]]));
      r  = v;
      if (v.y > 0) begin
         r.x   = v.x + dx;
         r.y   = v.y - dy;
         r.acc = v.acc + t;
      end else begin
         r.x   = v.x - dx;
         r.y   = v.y + dy;
         r.acc = v.acc - t;
      end
      return r;
   endfunction

endpackage

@@ hdl/two_link_inverse_kinematics_unit.sv @@
// Two-link planar inverse kinematics: foot target in, hip and knee angles out.
//
// Takes one target (y, z) per clock and returns hip and knee angles in Q(FRAC_BITS)
// radians, wrapped to (-half turn, half turn], plus an out-of-reach flag in rsp_tuser.
// A request is fully pipelined: 30 restoring divider stages for the cosine, 31 square
// root stages for the sine, three parallel CORDIC lanes of min(CORDIC_STAGES, 30)
// stages each, and a short wrap and rounding tail. Throughput is one request per cycle;
// a two-entry output buffer lets the pipe take a new request while a result waits, and
// the whole pipe freezes only when that buffer is full. Configuration registers must be
// written only while the unit is idle.
module two_link_inverse_kinematics_unit #(
   parameter int FRAC_BITS     = tlik_pkg::FRAC_BITS_DEF,
   parameter int CORDIC_STAGES = tlik_pkg::CORDIC_STAGES_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [39:0]                     req_tdata,   // target_y [19:0], target_z [39:20]
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [39:0]                     rsp_tdata,   // hip_angle [18:0], knee_angle [37:19]
   output logic [0:0]                      rsp_tuser,   // out_of_reach [0]
   input  logic                            csr_wr_en,
   input  logic [tlik_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  logic [18:0]                     csr_wdata
);

   localparam int NSTG = (CORDIC_STAGES < tlik_pkg::TABLE_LEN) ? CORDIC_STAGES
                                                                : tlik_pkg::TABLE_LEN;
   localparam int CW   = tlik_pkg::CW;
   localparam int GSH  = 30 - FRAC_BITS;
   localparam int AW   = (19 + GSH + 3 > 37) ? (19 + GSH + 3) : 37;
   localparam int HW   = AW - 20;
   localparam int PW   = HW + 21;
   localparam int QW   = PW - 32;

   localparam logic signed [AW-1:0] HALF_S    = AW'($signed({1'b0, tlik_pkg::Q30_HALF}));
   localparam logic signed [AW-1:0] FULL_S    = AW'($signed({1'b0, tlik_pkg::Q30_FULL}));
   localparam logic signed [AW-1:0] QUARTER_S =
      AW'($signed({1'b0, tlik_pkg::Q30_QUARTER}));
   localparam logic signed [33:0]   FULL_M    = $signed({1'b0, tlik_pkg::Q30_FULL});
   localparam logic signed [21:0]   RECIP_S   = $signed({1'b0, tlik_pkg::TURN_RECIP});
   localparam logic signed [AW-1:0] ROUND_S   = AW'(1) <<< (GSH - 1);
   localparam logic signed [AW-1:0] OUT_MAX   = AW'(262143);
   localparam logic signed [AW-1:0] OUT_MIN   = -AW'(262144);

   // one conditional turn correction toward (-half, half]
   function automatic logic signed [AW-1:0] wrap_step(input logic signed [AW-1:0] v);
      logic signed [AW-1:0] r;
      r = v;
      if (v > HALF_S) begin
         r = v - FULL_S;
      end else if (v <= -HALF_S) begin
         r = v + FULL_S;
      end
      return r;
   endfunction

   // ---------------------------------------------------------------------------
   // configuration registers
   logic [18:0]        r1_ff, r2_ff;
   logic signed [18:0] g1_ff, g2_ff;
   logic [18:0]        r1e, r2e;

   always_ff @(posedge clock) begin
      if (reset) begin
         r1_ff <= tlik_pkg::LINK_LEN_RESET;
         r2_ff <= tlik_pkg::LINK_LEN_RESET;
         g1_ff <= '0;
         g2_ff <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_addr)
            tlik_pkg::CSR_UPPER_LEN:    r1_ff <= csr_wdata;
            tlik_pkg::CSR_LOWER_LEN:    r2_ff <= csr_wdata;
            tlik_pkg::CSR_UPPER_OFFSET: g1_ff <= $signed(csr_wdata);
            tlik_pkg::CSR_LOWER_OFFSET: g2_ff <= $signed(csr_wdata);
            default: ;
         endcase
      end
   end

   // a zero link length counts as one
   assign r1e = (r1_ff == '0) ? 19'd1 : r1_ff;
   assign r2e = (r2_ff == '0) ? 19'd1 : r2_ff;

   // pipe advance: frozen only while the output buffer is full
   logic en;
   logic skid_vld_ff;
   assign en         = ~skid_vld_ff;
   assign req_tready = en;

   // ---------------------------------------------------------------------------
   // stage 1: squares and link product
   logic signed [19:0] ty_in, tz_in;
   logic signed [39:0] yy_in, zz_in;
   logic [38:0]        yy_ff, zz_ff;
   logic [37:0]        rr1_ff, rr2_ff, r1r2_ff;
   logic               s1_vld_ff;
   tlik_pkg::side_type s1_side_ff;

   assign ty_in = $signed(req_tdata[19:0]);
   assign tz_in = $signed(req_tdata[39:20]);
   assign yy_in = ty_in * ty_in;
   assign zz_in = tz_in * tz_in;

   always_ff @(posedge clock) begin
      if (en) begin
         yy_ff      <= yy_in[38:0];
         zz_ff      <= zz_in[38:0];
         rr1_ff     <= r1e * r1e;
         rr2_ff     <= r2e * r2e;
         r1r2_ff    <= r1e * r2e;
         s1_side_ff <= '{neg: 1'b0, sat: 1'b0, far: 1'b0, ty: ty_in, tz: tz_in};
      end
   end

   // ---------------------------------------------------------------------------
   // stage 2: numerator, magnitude and saturation test
   logic signed [40:0] num_in, negnum_in;
   logic [39:0]        mag_in;
   logic [38:0]        den_in;
   tlik_pkg::side_type s2_side_in;

   assign num_in    = $signed({2'b00, yy_ff}) + $signed({2'b00, zz_ff})
                    - $signed({3'b000, rr1_ff}) - $signed({3'b000, rr2_ff});
   assign negnum_in = -num_in;
   assign mag_in    = num_in[40] ? negnum_in[39:0] : num_in[39:0];
   assign den_in    = {r1r2_ff, 1'b0};

   always_comb begin
      s2_side_in     = s1_side_ff;
      s2_side_in.neg = num_in[40];
      s2_side_in.sat = mag_in >= {1'b0, den_in};
      s2_side_in.far = mag_in >  {1'b0, den_in};
   end

   // divider: index 0 holds stage 2, one quotient bit per stage
   logic [39:0]        drem_ff  [0:30];
   logic [29:0]        dq_ff    [0:30];
   logic [38:0]        dden_ff  [0:30];
   tlik_pkg::side_type dside_ff [0:30];
   logic               dvld_ff  [0:30];

   always_ff @(posedge clock) begin
      if (en) begin
         drem_ff[0]  <= mag_in;
         dq_ff[0]    <= '0;
         dden_ff[0]  <= den_in;
         dside_ff[0] <= s2_side_in;
      end
   end

   for (genvar k = 0; k < 30; k++) begin : g_div
      logic [39:0] sh_in;
      logic        ge_in;
      assign sh_in = {drem_ff[k][38:0], 1'b0};
      assign ge_in = sh_in >= {1'b0, dden_ff[k]};
      always_ff @(posedge clock) begin
         if (en) begin
            drem_ff[k+1]  <= ge_in ? (sh_in - {1'b0, dden_ff[k]}) : sh_in;
            dq_ff[k+1]    <= {dq_ff[k][28:0], ge_in};
            dden_ff[k+1]  <= dden_ff[k];
            dside_ff[k+1] <= dside_ff[k];
         end
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            dvld_ff[k+1] <= 1'b0;
         end else if (en) begin
            dvld_ff[k+1] <= dvld_ff[k];
         end
      end
   end

   // ---------------------------------------------------------------------------
   // cosine and its square
   logic [30:0]        cmag_in;
   logic signed [31:0] c_in;
   logic signed [31:0] cs_c_ff;
   logic [61:0]        cs_sq_ff;
   tlik_pkg::side_type cs_side_ff;
   logic               cs_vld_ff;

   assign cmag_in = dside_ff[30].sat ? 31'h4000_0000 : {1'b0, dq_ff[30]};
   assign c_in    = dside_ff[30].neg ? -$signed({1'b0, cmag_in}) : $signed({1'b0, cmag_in});

   always_ff @(posedge clock) begin
      if (en) begin
         cs_c_ff    <= c_in;
         cs_sq_ff   <= cmag_in * cmag_in;
         cs_side_ff <= dside_ff[30];
      end
   end

   // square root: index 0 holds 1 - c*c, one result bit per stage
   logic [61:0]        qn_ff    [0:31];
   logic [61:0]        qr_ff    [0:31];
   logic signed [31:0] qc_ff    [0:31];
   tlik_pkg::side_type qside_ff [0:31];
   logic               qvld_ff  [0:31];

   always_ff @(posedge clock) begin
      if (en) begin
         qn_ff[0]    <= {2'b01, 60'b0} - cs_sq_ff;
         qr_ff[0]    <= '0;
         qc_ff[0]    <= cs_c_ff;
         qside_ff[0] <= cs_side_ff;
      end
   end

   for (genvar k = 0; k < 31; k++) begin : g_sqrt
      logic [61:0] bit_in, t_in;
      logic        ge_in;
      assign bit_in = 62'd1 << (2 * (30 - k));
      assign t_in   = qr_ff[k] + bit_in;
      assign ge_in  = qn_ff[k] >= t_in;
      always_ff @(posedge clock) begin
         if (en) begin
            qn_ff[k+1]    <= ge_in ? (qn_ff[k] - t_in) : qn_ff[k];
            qr_ff[k+1]    <= ge_in ? ((qr_ff[k] >> 1) + bit_in) : (qr_ff[k] >> 1);
            qc_ff[k+1]    <= qc_ff[k];
            qside_ff[k+1] <= qside_ff[k];
         end
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            qvld_ff[k+1] <= 1'b0;
         end else if (en) begin
            qvld_ff[k+1] <= qvld_ff[k];
         end
      end
   end

   // ---------------------------------------------------------------------------
   // link products for the elbow vector
   logic [30:0]        p_s_ff;
   logic signed [31:0] p_c_ff;
   logic [49:0]        p_r2s_ff;
   logic signed [51:0] p_r2c_ff;
   tlik_pkg::side_type p_side_ff;
   logic               p_vld_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         p_s_ff    <= qr_ff[31][30:0];
         p_c_ff    <= qc_ff[31];
         p_r2s_ff  <= r2e * qr_ff[31][30:0];
         p_r2c_ff  <= $signed({1'b0, r2e}) * qc_ff[31];
         p_side_ff <= qside_ff[31];
      end
   end

   // CORDIC lanes: 0 knee cosine, 1 target, 2 elbow
   logic signed [CW-1:0] vy_in [0:2];
   logic signed [CW-1:0] vx_in [0:2];
   tlik_pkg::cvec_type   cv_ff    [0:NSTG][0:2];
   tlik_pkg::side_type   cside_ff [0:NSTG];
   logic                 cvld_ff  [0:NSTG];

   assign vy_in[0] = $signed({3'b000, p_s_ff, 20'b0});
   assign vx_in[0] = $signed({{2{p_c_ff[31]}}, p_c_ff, 20'b0});
   assign vy_in[1] = $signed({{4{p_side_ff.tz[19]}}, p_side_ff.tz, 30'b0});
   assign vx_in[1] = $signed({{4{p_side_ff.ty[19]}}, p_side_ff.ty, 30'b0});
   assign vy_in[2] = -$signed({4'b0000, p_r2s_ff});
   assign vx_in[2] = $signed({5'b00000, r1e, 30'b0})
                   + $signed({{2{p_r2c_ff[51]}}, p_r2c_ff});

   always_ff @(posedge clock) begin
      if (en) begin
         for (int j = 0; j < 3; j++) begin
            cv_ff[0][j] <= tlik_pkg::pre_rotate(vy_in[j], vx_in[j]);
         end
         cside_ff[0] <= p_side_ff;
      end
   end

   for (genvar k = 0; k < NSTG; k++) begin : g_cordic
      always_ff @(posedge clock) begin
         if (en) begin
            for (int j = 0; j < 3; j++) begin
               cv_ff[k+1][j] <= tlik_pkg::cordic_step(cv_ff[k][j], k);
            end
            cside_ff[k+1] <= cside_ff[k];
         end
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            cvld_ff[k+1] <= 1'b0;
         end else if (en) begin
            cvld_ff[k+1] <= cvld_ff[k];
         end
      end
   end

   // ---------------------------------------------------------------------------
   // joint angles, turn reduction, rounding
   logic signed [tlik_pkg::ANG_W-1:0] ang_in [0:2];
   logic signed [AW-1:0] g1s_in, g2s_in;

   for (genvar j = 0; j < 3; j++) begin : g_ang
      assign ang_in[j] = cv_ff[NSTG][j].zero ? '0 : cv_ff[NSTG][j].acc;
   end
   assign g1s_in = AW'(g1_ff) <<< GSH;
   assign g2s_in = AW'(g2_ff) <<< GSH;

   logic signed [AW-1:0] f1_hip_ff, f1_knee_ff;
   logic signed [PW-1:0] f2_ph_ff, f2_pk_ff;
   logic signed [AW-1:0] f2_hip_ff, f2_knee_ff;
   logic signed [AW-1:0] f3_qh_ff, f3_qk_ff, f3_hip_ff, f3_knee_ff;
   logic signed [AW-1:0] f4_hip_ff, f4_knee_ff;
   logic signed [AW-1:0] f5_hip_ff, f5_knee_ff;
   logic signed [AW-1:0] f6_hip_ff, f6_knee_ff;
   logic [18:0]          f7_hip_ff, f7_knee_ff;
   logic [6:0]           f_far_ff;
   logic [6:0]           f_vld_ff;

   logic signed [HW-1:0] hh_in, hk_in;
   logic signed [QW-1:0] qh_in, qk_in;
   logic signed [QW+33:0] qfh_in, qfk_in;
   logic signed [AW-1:0] rh_in, rk_in, oh_in, ok_in;

   assign hh_in  = HW'(f1_hip_ff >>> 20);
   assign hk_in  = HW'(f1_knee_ff >>> 20);
   assign qh_in  = QW'(f2_ph_ff >>> 32);
   assign qk_in  = QW'(f2_pk_ff >>> 32);
   assign qfh_in = qh_in * FULL_M;
   assign qfk_in = qk_in * FULL_M;
   assign rh_in  = (f6_hip_ff + ROUND_S) >>> GSH;
   assign rk_in  = (f6_knee_ff + ROUND_S) >>> GSH;
   assign oh_in  = (rh_in > OUT_MAX) ? OUT_MAX : ((rh_in < OUT_MIN) ? OUT_MIN : rh_in);
   assign ok_in  = (rk_in > OUT_MAX) ? OUT_MAX : ((rk_in < OUT_MIN) ? OUT_MIN : rk_in);

   always_ff @(posedge clock) begin
      if (en) begin
         // hip = -(target - elbow) - gamma1 - quarter; knee = acos + gamma1 + gamma2 - quarter
         f1_hip_ff  <= AW'(ang_in[2]) - AW'(ang_in[1]) - g1s_in - QUARTER_S;
         f1_knee_ff <= AW'(ang_in[0]) + g1s_in + g2s_in - QUARTER_S;
         // coarse turn count by reciprocal
         f2_ph_ff   <= hh_in * RECIP_S;
         f2_pk_ff   <= hk_in * RECIP_S;
         f2_hip_ff  <= f1_hip_ff;
         f2_knee_ff <= f1_knee_ff;
         f3_qh_ff   <= AW'(qfh_in);
         f3_qk_ff   <= AW'(qfk_in);
         f3_hip_ff  <= f2_hip_ff;
         f3_knee_ff <= f2_knee_ff;
         f4_hip_ff  <= f3_hip_ff - f3_qh_ff;
         f4_knee_ff <= f3_knee_ff - f3_qk_ff;
         // final corrections
         f5_hip_ff  <= wrap_step(f4_hip_ff);
         f5_knee_ff <= wrap_step(f4_knee_ff);
         f6_hip_ff  <= wrap_step(f5_hip_ff);
         f6_knee_ff <= wrap_step(f5_knee_ff);
         f7_hip_ff  <= oh_in[18:0];
         f7_knee_ff <= ok_in[18:0];
         f_far_ff   <= {f_far_ff[5:0], cside_ff[NSTG].far};
      end
   end

   // valid bits of the ungenerated stages
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff  <= 1'b0;
         dvld_ff[0] <= 1'b0;
         cs_vld_ff  <= 1'b0;
         qvld_ff[0] <= 1'b0;
         p_vld_ff   <= 1'b0;
         cvld_ff[0] <= 1'b0;
         f_vld_ff   <= '0;
      end else if (en) begin
         s1_vld_ff  <= req_tvalid;
         dvld_ff[0] <= s1_vld_ff;
         cs_vld_ff  <= dvld_ff[30];
         qvld_ff[0] <= cs_vld_ff;
         p_vld_ff   <= qvld_ff[31];
         cvld_ff[0] <= p_vld_ff;
         f_vld_ff   <= {f_vld_ff[5:0], cvld_ff[NSTG]};
      end
   end

   // ---------------------------------------------------------------------------
   // output register with one skid entry
   logic        rsp_vld_ff;
   logic        hold;
   logic [37:0] rsp_data_ff, skid_data_ff;
   logic        rsp_far_ff, skid_far_ff;

   assign hold = rsp_vld_ff & ~rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff  <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else if (hold) begin
         if (en & f_vld_ff[6]) begin
            skid_vld_ff <= 1'b1;
         end
      end else if (skid_vld_ff) begin
         rsp_vld_ff  <= 1'b1;
         skid_vld_ff <= 1'b0;
      end else begin
         rsp_vld_ff <= f_vld_ff[6];
      end
   end

   always_ff @(posedge clock) begin
      if (hold) begin
         if (en) begin
            skid_data_ff <= {f7_knee_ff, f7_hip_ff};
            skid_far_ff  <= f_far_ff[6];
         end
      end else if (skid_vld_ff) begin
         rsp_data_ff <= skid_data_ff;
         rsp_far_ff  <= skid_far_ff;
      end else begin
         rsp_data_ff <= {f7_knee_ff, f7_hip_ff};
         rsp_far_ff  <= f_far_ff[6];
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = {2'b00, rsp_data_ff};
   assign rsp_tuser  = rsp_far_ff;

endmodule

@@ tb/sv/tb_two_link_inverse_kinematics_unit.sv @@
// Self-checking testbench for the two-link inverse kinematics unit.
`timescale 1ns / 1ps

module tb_two_link_inverse_kinematics_unit;

   localparam int LATENCY   = 93;
   localparam int N_RANDOM  = 1450;
   localparam int MAX_CYCLE = 1000000;

   typedef struct packed {
      logic [18:0] hip;
      logic [18:0] knee;
      logic        far;
   } angles_type;

   // arctangent table in Q30, local copy
   localparam longint ATAN_TBL [0:29] = '{
      843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
      16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144, 131072,
      65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32,
      16, 8, 4, 2};
   localparam longint HALF_T    = 64'sd3373259426;
   localparam longint QUARTER_T = 64'sd1686629713;
   localparam longint FULL_T    = 64'sd6746518852;

   // Predictor of joint angles with its own register copy
   class angle_scoreboard;
      logic [18:0] r1_reg, r2_reg, g1_reg, g2_reg;
      angles_type  pending_angles[$];
      int          errors;
      int          checked;
      int          far_count;

      function void reset_regs();
         r1_reg = tlik_pkg::LINK_LEN_RESET;
         r2_reg = tlik_pkg::LINK_LEN_RESET;
         g1_reg = '0;
         g2_reg = '0;
      endfunction

      function void write_reg(logic [tlik_pkg::CSR_ADDR_W-1:0] idx, logic [18:0] val);
         case (idx)
            tlik_pkg::CSR_UPPER_LEN:    r1_reg = val;
            tlik_pkg::CSR_LOWER_LEN:    r2_reg = val;
            tlik_pkg::CSR_UPPER_OFFSET: g1_reg = val;
            tlik_pkg::CSR_LOWER_OFFSET: g2_reg = val;
            default: ;
         endcase
      endfunction

      function longint fshift(longint v, int s);
         return v >>> s;
      endfunction

      function longint isqrt(longint unsigned n);
         longint unsigned res, bitv;
         res = 0;
         bitv = 64'd1 << 62;
         while (bitv > n) bitv >>= 2;
         while (bitv != 0) begin
            if (n >= res + bitv) begin
               n = n - (res + bitv);
               res = (res >> 1) + bitv;
            end else begin
               res = res >> 1;
            end
            bitv >>= 2;
         end
         return longint'(res);
      endfunction

      // vectoring CORDIC atan2 in Q30
      function longint vec_atan2(longint y, longint x);
         longint acc, t, dx, dy;
         acc = 0;
         if (x == 0 && y == 0) return 0;
         if (x < 0) begin
            if (y >= 0) begin
               t = x; x = y; y = -t; acc = QUARTER_T;
            end else begin
               t = x; x = -y; y = t; acc = -QUARTER_T;
            end
         end
         for (int i = 0; i < tlik_pkg::CORDIC_STAGES_DEF; i++) begin
            dx = fshift(y, i);
            dy = fshift(x, i);
            if (y > 0) begin
               x += dx; y -= dy; acc += ATAN_TBL[i];
            end else begin
               x -= dx; y += dy; acc -= ATAN_TBL[i];
            end
         end
         return acc;
      endfunction

      function longint wrap(longint v);
         while (v > HALF_T) v -= FULL_T;
         while (v <= -HALF_T) v += FULL_T;
         return v;
      endfunction

      function logic [18:0] to_q16(longint v);
         longint q;
         q = (v + (64'sd1 << 13)) >>> 14;
         if (q > 262143) q = 262143;
         if (q < -262144) q = -262144;
         return q[18:0];
      endfunction

      // note an accepted request and queue its expected angles
      function void note_request(logic [39:0] data);
         longint ty, tz, r1, r2, g1, g2, num, den, mag, cmag, rem, c, s, a, b;
         angles_type e;
         ty = longint'($signed(data[19:0]));
         tz = longint'($signed(data[39:20]));
         r1 = (r1_reg == 0) ? 1 : longint'(r1_reg);
         r2 = (r2_reg == 0) ? 1 : longint'(r2_reg);
         g1 = longint'($signed(g1_reg)) * (64'sd1 << 14);
         g2 = longint'($signed(g2_reg)) * (64'sd1 << 14);
         num = ty * ty + tz * tz - r1 * r1 - r2 * r2;
         den = 2 * r1 * r2;
         mag = (num < 0) ? -num : num;
         e.far = 1'b0;
         if (mag >= den) begin
            cmag = 64'sd1 << 30;
            e.far = (mag > den);
         end else begin
            rem = mag;
            cmag = 0;
            for (int i = 0; i < 30; i++) begin
               rem = rem << 1;
               cmag = cmag << 1;
               if (rem >= den) begin
                  rem -= den;
                  cmag |= 1;
               end
            end
         end
         c = (num < 0) ? -cmag : cmag;
         s = isqrt((64'd1 << 60) - longint'(cmag * cmag));
         a = -vec_atan2(s * (64'sd1 << 20), c * (64'sd1 << 20));
         b = vec_atan2(tz * (64'sd1 << 30), ty * (64'sd1 << 30))
             - vec_atan2(-(r2 * s), r1 * (64'sd1 << 30) + r2 * c);
         e.hip  = to_q16(wrap(-b - g1 - QUARTER_T));
         e.knee = to_q16(wrap(-a + g1 + g2 - QUARTER_T));
         pending_angles.push_back(e);
      endfunction

      // compare a result against the oldest expectation
      function void check_result(logic [39:0] data, logic [0:0] user);
         angles_type e;
         checked++;
         if (pending_angles.size() == 0) begin
            $display("%0t: unexpected result hip=%0d knee=%0d", $time,
                     $signed(data[18:0]), $signed(data[37:19]));
            errors++;
            return;
         end
         e = pending_angles.pop_front();
         if (e.far) far_count++;
         if (data[18:0] !== e.hip) begin
            $display("%0t: hip_angle expected %0d actual %0d", $time,
                     $signed(e.hip), $signed(data[18:0]));
            errors++;
         end
         if (data[37:19] !== e.knee) begin
            $display("%0t: knee_angle expected %0d actual %0d", $time,
                     $signed(e.knee), $signed(data[37:19]));
            errors++;
         end
         if (user[0] !== e.far) begin
            $display("%0t: out_of_reach expected %0b actual %0b", $time, e.far, user[0]);
            errors++;
         end
      endfunction
   endclass

   logic                            clock;
   logic                            reset;
   logic                            req_tvalid;
   logic                            req_tready;
   logic [39:0]                     req_tdata;   // target_y [19:0], target_z [39:20]
   logic                            rsp_tvalid;
   logic                            rsp_tready;
   logic [39:0]                     rsp_tdata;   // hip_angle [18:0], knee_angle [37:19]
   logic [0:0]                      rsp_tuser;   // out_of_reach [0]
   logic                            csr_wr_en;
   logic [tlik_pkg::CSR_ADDR_W-1:0] csr_addr;
   logic [18:0]                     csr_wdata;

   angle_scoreboard sb;
   int  cycle_count;
   bit  calm_mode;     // no idling on either side
   bit  hold_rsp;      // long receiver hold-off

   two_link_inverse_kinematics_unit DUT (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .csr_wr_en(csr_wr_en), .csr_addr(csr_addr), .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // cycle limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > MAX_CYCLE) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // receiver: random stalls, a long hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata, rsp_tuser);
         rsp_tready <= !hold_rsp && (calm_mode || $urandom_range(99) >= 25);
      end
   end

   task automatic write_csr(logic [tlik_pkg::CSR_ADDR_W-1:0] idx, logic [18:0] val);
      csr_wr_en <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= val;
      @(posedge clock);
      sb.write_reg(idx, val);
      csr_wr_en <= 1'b0;
   endtask

   // offer one request and hold it until accepted
   task automatic send_target(logic signed [19:0] ty, logic signed [19:0] tz);
      while (!calm_mode && $urandom_range(99) < 25) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {tz, ty};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_request({tz, ty});
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.pending_angles.size() != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
   endtask

   task automatic set_geometry(logic [18:0] r1, logic [18:0] r2,
                               logic [18:0] g1, logic [18:0] g2);
      write_csr(tlik_pkg::CSR_UPPER_LEN, r1);
      write_csr(tlik_pkg::CSR_LOWER_LEN, r2);
      write_csr(tlik_pkg::CSR_UPPER_OFFSET, g1);
      write_csr(tlik_pkg::CSR_LOWER_OFFSET, g2);
   endtask

   // reachable-ish target around the link lengths, or full-range noise
   task automatic send_random_target();
      longint lim;
      logic signed [19:0] ty, tz;
      lim = longint'(sb.r1_reg) + longint'(sb.r2_reg) + 2;
      if (lim > 524287) lim = 524287;
      if ($urandom_range(99) < 75) begin
         ty = 20'(int'($urandom_range(32'(2 * lim))) - int'(lim));
         tz = 20'(int'($urandom_range(32'(2 * lim))) - int'(lim));
      end else begin
         ty = 20'($urandom);
         tz = 20'($urandom);
      end
      send_target(ty, tz);
   endtask

   initial begin
      logic [18:0] g;
      sb = new();
      sb.reset_regs();
      cycle_count = 0;
      calm_mode = 1'b0;
      hold_rsp  = 1'b0;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      csr_wr_en  <= 1'b0;
      csr_addr   <= '0;
      csr_wdata  <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: field extremes, origin, boundary of reach, degenerate links
      send_target(20'sd0, 20'sd0);
      send_target(20'sd39322, 20'sd0);
      send_target(20'sd0, -20'sd39322);
      send_target(20'sd0, 20'sd39323);
      send_target(-20'sd524288, -20'sd524288);
      send_target(20'sd524287, 20'sd524287);
      send_target(-20'sd524288, 20'sd524287);
      send_target(20'sd524287, -20'sd524288);
      send_target(-20'sd10000, -20'sd20000);
      send_target(20'sd1, 20'sd0);
      drain();
      set_geometry(19'd0, 19'd0, 19'sd205887, 19'sd205887);
      send_target(20'sd0, 20'sd0);
      send_target(20'sd2, 20'sd0);
      send_target(20'sd1, 20'sd1);
      send_target(20'sd3, -20'sd3);
      drain();
      set_geometry(19'd524287, 19'd524287, -19'sd205887, -19'sd205887);
      send_target(20'sd0, 20'sd0);
      send_target(20'sd524287, 20'sd0);
      send_target(-20'sd524288, 20'sd1);
      send_target(20'sd300000, -20'sd400000);
      drain();
      // unused index must be ignored
      write_csr(4'd7, 19'h7ffff);
      set_geometry(19'd3, 19'd4, 19'sd1, -19'sd1);
      send_target(20'sd5, 20'sd0);
      send_target(20'sd7, 20'sd0);
      send_target(20'sd1, 20'sd0);
      drain();

      // random phases, each with new geometry
      for (int ph = 0; ph < 8; ph++) begin
         case (ph)
            0: set_geometry(tlik_pkg::LINK_LEN_RESET, tlik_pkg::LINK_LEN_RESET,
                            19'd0, 19'd0);
            1: set_geometry(19'd1, 19'd524287, 19'sd205887, -19'sd205887);
            2: set_geometry(19'd524287, 19'd1, -19'sd205887, 19'sd205887);
            default: begin
               g = 19'(int'($urandom_range(411774)) - 205887);
               set_geometry(19'($urandom_range(1, (1 << $urandom_range(3, 19)) - 1)),
                            19'($urandom_range(1, (1 << $urandom_range(3, 19)) - 1)),
                            g, 19'(int'($urandom_range(411774)) - 205887));
            end
         endcase
         calm_mode = (ph == 4);
         if (ph == 2) begin
            // receiver stalls long while requests keep coming
            fork
               begin
                  hold_rsp = 1'b1;
                  repeat (400) @(posedge clock);
                  hold_rsp = 1'b0;
               end
            join_none
         end
         for (int n = 0; n < N_RANDOM / 8; n++) send_random_target();
         drain();
      end
      calm_mode = 1'b0;

      $display("Checked %0d results over 12 geometries, %0d out of reach.",
               sb.checked, sb.far_count);
      if (sb.errors == 0 && sb.pending_angles.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end
endmodule
